// File: src/arm_elf_rel_relocator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ARM REL relocator
// Clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ARM_ELF_REL_RELOCATOR_ASSERT_SVH
`define ARM_ELF_REL_RELOCATOR_ASSERT_SVH

// Property that must hold at every sampled edge.
`define AER_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Implication whose effect is checked in the cycle after the cause.
`define AER_ASSERT_NEXT(lbl, cause, effect, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) cause |=> effect) else $error(msg);

`endif

// File: src/arm_rel_pkg.sv
// ---------------------------------------------------------------------------
// ARM REL relocator package
// Shared constants, relocation codes and interface types.
// ---------------------------------------------------------------------------
package arm_rel_pkg;

   // Veneer table geometry.
   localparam int VENEER_DEPTH = 16;
   localparam int IDX_W  = (VENEER_DEPTH > 1) ? $clog2(VENEER_DEPTH) : 1;
   localparam int FILL_W = $clog2(VENEER_DEPTH + 1);
   localparam int ENT_W  = 5;
   localparam int CNT_W  = (FILL_W > ENT_W) ? FILL_W : ENT_W;
   localparam int VIDX_W = 4;

   // Relocation type numbers.
   localparam logic [7:0] RT_NONE       = 8'd0;
   localparam logic [7:0] RT_PC24       = 8'd1;
   localparam logic [7:0] RT_ABS32      = 8'd2;
   localparam logic [7:0] RT_REL32      = 8'd3;
   localparam logic [7:0] RT_THM_CALL   = 8'd10;
   localparam logic [7:0] RT_GLOB_DAT   = 8'd21;
   localparam logic [7:0] RT_JUMP_SLOT  = 8'd22;
   localparam logic [7:0] RT_RELATIVE   = 8'd23;
   localparam logic [7:0] RT_PLT32      = 8'd27;
   localparam logic [7:0] RT_CALL       = 8'd28;
   localparam logic [7:0] RT_JUMP24     = 8'd29;
   localparam logic [7:0] RT_THM_JUMP24 = 8'd30;
   localparam logic [7:0] RT_TARGET1    = 8'd38;
   localparam logic [7:0] RT_V4BX       = 8'd40;
   localparam logic [7:0] RT_PREL31     = 8'd42;
   localparam logic [7:0] RT_MOVW_ABS   = 8'd43;
   localparam logic [7:0] RT_MOVT_ABS   = 8'd44;

   // Register indexes of the CSR port.
   localparam logic [3:0] CSR_VENEER_BASE    = 4'd0;
   localparam logic [3:0] CSR_VENEER_ENTRIES = 4'd1;

   // Instruction field masks.
   localparam logic [31:0] V4BX_KEEP = 32'hf000000f;
   localparam logic [31:0] V4BX_SET  = 32'h01a0f000;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_UNKNOWN,
      STAT_FULL,
      STAT_RANGE
   } status_type;

   // Result of the patch datapath for one relocation.
   typedef struct packed {
      logic [31:0] word;
      status_type  status;
      logic        need_veneer;
      logic [31:0] pa;           // branch addend minus place
   } patch_type;

   // Answer of the veneer table.
   typedef struct packed {
      logic             done;
      logic             full;
      logic             created;
      logic [IDX_W-1:0] idx;
   } vt_rsp_type;

   typedef enum logic [1:0] {
      VT_IDLE,
      VT_SCAN,
      VT_DECIDE
   } vt_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_CALC,
      ST_VENEER,
      ST_FIX,
      ST_OUT
   } top_state_type;

endpackage

// File: src/arm_rel_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module arm_rel_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/arm_rel_patch.sv
// ---------------------------------------------------------------------------
// ARM REL patch datapath
// Computes the patched word and status for every supported type.
// ---------------------------------------------------------------------------
module arm_rel_patch import arm_rel_pkg::*; (
   input  logic [7:0]  reloc_type,
   input  logic [31:0] word,
   input  logic [31:0] base,
   input  logic [31:0] sym,
   input  logic [31:0] diff,     // symbol minus place
   input  logic [31:0] place,
   output patch_type   result
);

   logic [31:0] br_add;
   logic [31:0] br_t;
   logic        br_far;
   logic [31:0] w_plus_d;
   logic [31:0] mov_imm;
   logic [31:0] mov_t;
   logic [15:0] mov_v;
   logic [15:0] th_up;
   logic [15:0] th_lo;
   logic        th_sg;
   logic [31:0] th_off;
   logic [31:0] th_t;
   logic        th_ok;
   logic        th_j1;
   logic        th_j2;

   always_comb begin
      // ARM branch: 24-bit word offset, sign extended and scaled.
      br_add   = {{6{word[23]}}, word[23:0], 2'b00};
      br_t     = diff + br_add;
      br_far   = (br_t[31:25] != 7'h00) && (br_t[31:25] != 7'h7f);
      w_plus_d = word + diff;

      // MOVW/MOVT: 16-bit signed addend split over imm4 and imm12.
      mov_imm = {{16{word[19]}}, word[19:16], word[11:0]};
      mov_t   = mov_imm + sym;
      mov_v   = (reloc_type == RT_MOVT_ABS) ? mov_t[31:16] : mov_t[15:0];

      // Thumb-2 BL/B.W: upper halfword in 15:0, lower halfword in 31:16.
      th_up  = word[15:0];
      th_lo  = word[31:16];
      th_sg  = th_up[10];
      th_off = {{7{th_sg}}, th_sg, ~(th_lo[13] ^ th_sg), ~(th_lo[11] ^ th_sg),
                th_up[9:0], th_lo[10:0], 1'b0};
      th_t   = th_off + diff;
      // Odd target and within plus or minus 0xffffff.
      th_ok  = th_t[0] && ((th_t[31:24] == 8'h00) || (th_t[31:24] == 8'hff));
      th_j1  = th_t[24] ^ ~th_t[23];
      th_j2  = th_t[24] ^ ~th_t[22];

      result.word        = word;
      result.status      = STAT_OK;
      result.need_veneer = 1'b0;
      result.pa          = br_add - place;

      unique case (reloc_type) inside
         RT_NONE: begin
         end
         RT_ABS32, RT_TARGET1: begin
            result.word = word + sym;
         end
         RT_GLOB_DAT, RT_JUMP_SLOT: begin
            result.word = sym;
         end
         RT_RELATIVE: begin
            result.word = word + base;
         end
         RT_PC24, RT_PLT32, RT_CALL, RT_JUMP24: begin
            result.word        = {word[31:24], br_t[25:2]};
            result.need_veneer = br_far;
         end
         RT_REL32: begin
            result.word = w_plus_d;
         end
         RT_V4BX: begin
            result.word = (word & V4BX_KEEP) | V4BX_SET;
         end
         RT_PREL31: begin
            result.word = {word[31], w_plus_d[30:0]};
         end
         RT_MOVW_ABS, RT_MOVT_ABS: begin
            result.word = {word[31:20], mov_v[15:12], word[15:12], mov_v[11:0]};
         end
         RT_THM_CALL, RT_THM_JUMP24: begin
            if (th_ok) begin
               result.word = {th_lo[15:14], th_j1, th_lo[12], th_j2, th_t[11:1],
                              th_up[15:11], th_t[24], th_t[21:12]};
            end else begin
               result.status = STAT_RANGE;
            end
         end
         default: begin
            result.status = STAT_UNKNOWN;
         end
      endcase
   end

endmodule

// File: src/arm_rel_vtab.sv
// ---------------------------------------------------------------------------
// Veneer destination table
// Searches the filled entries one per cycle and appends on a miss while a usable entry is free.
// ---------------------------------------------------------------------------
module arm_rel_vtab import arm_rel_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      dest,
   input  logic [ENT_W-1:0] entries,
   output vt_rsp_type       rsp
);

   vt_state_type      state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] rd_ff, rd_in;
   logic [FILL_W-1:0] lim_ff, lim_in;
   logic [IDX_W-1:0]  cidx_ff, cidx_in;
   logic [31:0]       dest_ff, dest_in;
   vt_rsp_type        rsp_ff, rsp_in;

   logic [CNT_W-1:0]  usable;
   logic [CNT_W-1:0]  fill_ext;
   logic [CNT_W-1:0]  lim_now;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [31:0]       ram_rd_data;

   arm_rel_ram #(
      .WIDTH (32),
      .DEPTH (VENEER_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (dest_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= VT_IDLE;
         fill_ff  <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff   <= rd_in;
      lim_ff  <= lim_in;
      cidx_ff <= cidx_in;
      dest_ff <= dest_in;
   end

   always_comb begin
      usable   = (CNT_W'(entries) < CNT_W'(VENEER_DEPTH)) ? CNT_W'(entries)
                                                           : CNT_W'(VENEER_DEPTH);
      fill_ext = CNT_W'(fill_ff);
      lim_now  = (fill_ext < usable) ? fill_ext : usable;

      state_in    = state_ff;
      fill_in     = fill_ff;
      rd_in       = rd_ff;
      lim_in      = lim_ff;
      cidx_in     = cidx_ff;
      dest_in     = dest_ff;
      rsp_in      = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = fill_ff[IDX_W-1:0];
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_ff[IDX_W-1:0];

      unique case (state_ff)
         VT_IDLE: begin
            if (start) begin
               dest_in = dest;
               lim_in  = lim_now[FILL_W-1:0];
               if (lim_now == '0) begin
                  state_in = VT_DECIDE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  cidx_in     = '0;
                  rd_in       = FILL_W'(1);
                  state_in    = VT_SCAN;
               end
            end
         end
         VT_SCAN: begin
            // Data for entry cidx_ff arrives this cycle.
            if (ram_rd_data == dest_ff) begin
               rsp_in.done = 1'b1;
               rsp_in.idx  = cidx_ff;
               state_in    = VT_IDLE;
            end else if (rd_ff == lim_ff) begin
               state_in = VT_DECIDE;
            end else begin
               ram_rd_en = 1'b1;
               cidx_in   = rd_ff[IDX_W-1:0];
               rd_in     = rd_ff + FILL_W'(1);
            end
         end
         VT_DECIDE: begin
            rsp_in.done = 1'b1;
            if (fill_ext < usable) begin
               ram_wr_en      = 1'b1;
               fill_in        = fill_ff + FILL_W'(1);
               rsp_in.created = 1'b1;
               rsp_in.idx     = fill_ff[IDX_W-1:0];
            end else begin
               rsp_in.full = 1'b1;
            end
            state_in = VT_IDLE;
         end
         default: begin
            state_in = VT_IDLE;
         end
      endcase
   end

   assign rsp = rsp_ff;

endmodule

// File: src/arm_elf_rel_relocator.sv
// ---------------------------------------------------------------------------
// ARM ELF REL relocator
// Patches one relocation per request beat and routes far ARM branches
// through a table of long-jump veneers.
// A beat passes the address, patch and output states on its way to the
//    response register; a far branch adds a veneer search that does one RAM
//    read per entry, and a fix-up state unless the table is full.
// A new beat is taken only once the last one is in the response register.
// Reset clears the controller, the CSRs and the veneer fill count; the
//    veneer RAM is not cleared, since only filled entries are ever read.
// ---------------------------------------------------------------------------
`include "arm_elf_rel_relocator_assert.svh"

module arm_elf_rel_relocator import arm_rel_pkg::*; (
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_index,
   input  logic [31:0]       csr_wdata,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_reloc_type,
   input  logic [31:0]       req_section_base,
   input  logic [31:0]       req_place_offset,
   input  logic [31:0]       req_place_word,
   input  logic [31:0]       req_symbol_value,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_patched_word,
   output logic [1:0]        rsp_status,
   output logic              rsp_veneer_used,
   output logic              rsp_veneer_new,
   output logic [VIDX_W-1:0] rsp_veneer_index,
   output logic [31:0]       rsp_veneer_target
);

   // The controller walks one relocation through address, patch, optional
   // veneer lookup and fix-up, then hands it to the response register.
   // The response register lets the next request beat be taken while a
   // finished result still waits for rsp_ready.

   top_state_type state_ff, state_in;

   // Configuration registers.
   logic [31:0]      vbase_ff, vbase_in;
   logic [ENT_W-1:0] vent_ff, vent_in;

   // Captured request.
   logic [7:0]  type_ff, type_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] off_ff, off_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] sym_ff, sym_in;

   // Place address and symbol minus place.
   logic [31:0] place_ff, place_in;
   logic [31:0] diff_ff, diff_in;

   // Working result.
   logic [31:0]      res_word_ff, res_word_in;
   status_type       res_status_ff, res_status_in;
   logic             res_used_ff, res_used_in;
   logic             res_new_ff, res_new_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;
   logic [31:0]      pa_ff, pa_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_word_ff, rsp_word_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_used_ff, rsp_used_in;
   logic              rsp_new_ff, rsp_new_in;
   logic [VIDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [31:0]       rsp_tgt_ff, rsp_tgt_in;

   patch_type  patch;
   vt_rsp_type vt_rsp;
   logic       vt_start;
   logic [31:0] fix_t;
   logic [VIDX_W+IDX_W-1:0] idx_ext;

   arm_rel_patch u_patch (
      .reloc_type (type_ff),
      .word       (word_ff),
      .base       (base_ff),
      .sym        (sym_ff),
      .diff       (diff_ff),
      .place      (place_ff),
      .result     (patch)
   );

   arm_rel_vtab u_vtab (
      .clock   (clock),
      .reset   (reset),
      .start   (vt_start),
      .dest    (sym_ff),
      .entries (vent_ff),
      .rsp     (vt_rsp)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vbase_ff     <= '0;
         vent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vbase_ff     <= vbase_in;
         vent_ff      <= vent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      base_ff       <= base_in;
      off_ff        <= off_in;
      word_ff       <= word_in;
      sym_ff        <= sym_in;
      place_ff      <= place_in;
      diff_ff       <= diff_in;
      res_word_ff   <= res_word_in;
      res_status_ff <= res_status_in;
      res_used_ff   <= res_used_in;
      res_new_ff    <= res_new_in;
      res_idx_ff    <= res_idx_in;
      pa_ff         <= pa_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_tgt_ff    <= rsp_tgt_in;
   end

   // CSR writes are always accepted. Writes to unknown indexes are dropped.
   always_comb begin
      vbase_in = vbase_ff;
      vent_in  = vent_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_VENEER_BASE:    vbase_in = csr_wdata;
            CSR_VENEER_ENTRIES: vent_in  = csr_wdata[ENT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      base_in       = base_ff;
      off_in        = off_ff;
      word_in       = word_ff;
      sym_in        = sym_ff;
      place_in      = place_ff;
      diff_in       = diff_ff;
      res_word_in   = res_word_ff;
      res_status_in = res_status_ff;
      res_used_in   = res_used_ff;
      res_new_in    = res_new_ff;
      res_idx_in    = res_idx_ff;
      pa_in         = pa_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_tgt_in    = rsp_tgt_ff;
      vt_start      = 1'b0;

      // The response beat drains independently of the controller.
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // Far branch target: veneer entry address minus place plus addend.
      fix_t   = vbase_ff + (32'(res_idx_ff) << 3) + pa_ff;
      idx_ext = {{VIDX_W{1'b0}}, res_idx_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               type_in  = req_reloc_type;
               base_in  = req_section_base;
               off_in   = req_place_offset;
               word_in  = req_place_word;
               sym_in   = req_symbol_value;
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            place_in = base_ff + off_ff;
            diff_in  = sym_ff - base_ff - off_ff;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            res_status_in = patch.status;
            res_used_in   = 1'b0;
            res_new_in    = 1'b0;
            res_idx_in    = '0;
            pa_in         = patch.pa;
            // Any failing status returns the original word.
            res_word_in   = (patch.status == STAT_OK) ? patch.word : word_ff;
            if (patch.need_veneer) begin
               vt_start = 1'b1;
               state_in = ST_VENEER;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_VENEER: begin
            if (vt_rsp.done) begin
               if (vt_rsp.full) begin
                  res_status_in = STAT_FULL;
                  res_word_in   = word_ff;
                  state_in      = ST_OUT;
               end else begin
                  res_used_in = 1'b1;
                  res_new_in  = vt_rsp.created;
                  res_idx_in  = vt_rsp.idx;
                  state_in    = ST_FIX;
               end
            end
         end
         ST_FIX: begin
            // The veneer offset is not range checked again.
            res_word_in = {word_ff[31:24], fix_t[25:2]};
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = res_word_ff;
               rsp_status_in = res_status_ff;
               rsp_used_in   = res_used_ff;
               rsp_new_in    = res_new_ff;
               rsp_idx_in    = res_used_ff ? idx_ext[VIDX_W-1:0] : '0;
               rsp_tgt_in    = res_used_ff ? sym_ff : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_ready         = 1'b1;
   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_patched_word  = rsp_word_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_veneer_used   = rsp_used_ff;
   assign rsp_veneer_new    = rsp_new_ff;
   assign rsp_veneer_index  = rsp_idx_ff;
   assign rsp_veneer_target = rsp_tgt_ff;

   // A veneer is only reported on a successful relocation.
   `AER_ASSERT(a_used_ok, rsp_valid_ff && rsp_used_ff |-> rsp_status_ff == STAT_OK, "veneer on failed relocation")
   // A new entry always comes with veneer use.
   `AER_ASSERT(a_new_used, rsp_valid_ff && rsp_new_ff |-> rsp_used_ff, "new veneer without use")
   // An accepted request beat starts the address stage next cycle.
   `AER_ASSERT_NEXT(a_accept_addr, req_valid && req_ready, state_ff == ST_ADDR, "request not started")
   // The table answers only while the controller waits for it.
   `AER_ASSERT(a_vt_wait, vt_rsp.done |-> state_ff == ST_VENEER, "stray veneer table answer")

endmodule

// File: dv/tb_arm_elf_rel_relocator.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the ARM ELF REL relocator
// Drives relocation beats through the request channel and checks every response
// beat against a cycle-free model of the patch datapath and the veneer table,
// or the typed word and status of a directed row. A short directed table comes
// first, then random phases under several CSR settings and idling patterns.
// ---------------------------------------------------------------------------
module tb_arm_elf_rel_relocator import arm_rel_pkg::*; ();

   // No stretch of this many cycles passes without some beat in a healthy run.
   localparam int QUIET_LIMIT = 4000;

   // One relocation as it crosses the request channel.
   typedef struct packed {
      logic [7:0]  reloc_type;
      logic [31:0] section_base;
      logic [31:0] place_offset;
      logic [31:0] place_word;
      logic [31:0] symbol_value;
   } reloc_req_t;

   // One patch result as it crosses the response channel.
   typedef struct packed {
      logic [31:0]       patched_word;
      status_type        status;
      logic              veneer_used;
      logic              veneer_new;
      logic [VIDX_W-1:0] veneer_index;
      logic [31:0]       veneer_target;
   } reloc_rsp_t;

   // A row of the directed table. When typed is set, the expected word and
   // status are written into the row; otherwise the model supplies them.
   typedef struct packed {
      reloc_req_t  req;
      logic        typed;
      logic [31:0] exp_word;
      status_type  exp_status;
   } directed_row_t;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic [3:0]        csr_index;
   logic [31:0]       csr_wdata;
   logic              req_valid;
   logic              req_ready;
   logic [7:0]        req_reloc_type;
   logic [31:0]       req_section_base;
   logic [31:0]       req_place_offset;
   logic [31:0]       req_place_word;
   logic [31:0]       req_symbol_value;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [31:0]       rsp_patched_word;
   logic [1:0]        rsp_status;
   logic              rsp_veneer_used;
   logic              rsp_veneer_new;
   logic [VIDX_W-1:0] rsp_veneer_index;
   logic [31:0]       rsp_veneer_target;

   // Model copy of the CSRs and of the veneer table.
   logic [31:0] model_veneer_base;
   logic [4:0]  model_veneer_entries;
   logic [31:0] model_veneer_dest [VENEER_DEPTH];
   int          model_veneer_fill;

   reloc_rsp_t    predicted_patches [$];
   reloc_rsp_t    oldest_patch;
   directed_row_t directed_rows [$];
   logic [31:0]   far_targets [24];

   int mismatch_count     = 0;
   int results_seen       = 0;
   int quiet_cycles       = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   arm_elf_rel_relocator dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_reloc_type    (req_reloc_type),
      .req_section_base  (req_section_base),
      .req_place_offset  (req_place_offset),
      .req_place_word    (req_place_word),
      .req_symbol_value  (req_symbol_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_patched_word  (rsp_patched_word),
      .rsp_status        (rsp_status),
      .rsp_veneer_used   (rsp_veneer_used),
      .rsp_veneer_new    (rsp_veneer_new),
      .rsp_veneer_index  (rsp_veneer_index),
      .rsp_veneer_target (rsp_veneer_target)
   );

   // 2 ns clock: one ns high, one ns low.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // -----------------------------------------------------------------------
   // Patch model. Works out the response for one relocation and updates the
   // model veneer table the way the block does when it accepts the beat.
   // -----------------------------------------------------------------------
   function automatic reloc_rsp_t predict_relocation(input reloc_req_t rq);
      logic [31:0] p;
      logic [31:0] w;
      logic [31:0] s;
      logic [31:0] t;
      logic [31:0] addend;
      logic [15:0] up;
      logic [15:0] lo;
      logic        sg;
      logic        j1;
      logic        j2;
      int          usable;
      int          hit;
      reloc_rsp_t  r;
      p = rq.section_base + rq.place_offset;
      w = rq.place_word;
      s = rq.symbol_value;
      r.patched_word  = w;
      r.status        = STAT_OK;
      r.veneer_used   = 1'b0;
      r.veneer_new    = 1'b0;
      r.veneer_index  = '0;
      r.veneer_target = '0;
      case (rq.reloc_type)
         RT_NONE: ;
         RT_ABS32, RT_TARGET1: r.patched_word = w + s;
         RT_GLOB_DAT, RT_JUMP_SLOT: r.patched_word = s;
         RT_RELATIVE: r.patched_word = w + rq.section_base;
         RT_REL32: r.patched_word = w + s - p;
         RT_V4BX: r.patched_word = (w & V4BX_KEEP) | V4BX_SET;
         RT_PREL31: begin
            t = w + s - p;
            r.patched_word = {w[31], t[30:0]};
         end
         RT_MOVW_ABS, RT_MOVT_ABS: begin
            // 16-bit signed addend split over imm4:imm12.
            t = {{16{w[19]}}, w[19:16], w[11:0]} + s;
            if (rq.reloc_type == RT_MOVT_ABS) t = t >> 16;
            r.patched_word = {w[31:20], t[15:12], w[15:12], t[11:0]};
         end
         RT_PC24, RT_PLT32, RT_CALL, RT_JUMP24: begin
            addend = {{6{w[23]}}, w[23:0], 2'b00};
            t = s - p + addend;
            // Out of the 26-bit signed reach: go through a veneer.
            if (t[31:25] != 7'h7f && t[31:25] != 7'h00) begin
               usable = (model_veneer_entries > VENEER_DEPTH) ? VENEER_DEPTH
                        : int'(model_veneer_entries);
               hit = -1;
               for (int i = 0; i < usable && i < model_veneer_fill; i++) begin
                  if (hit < 0 && model_veneer_dest[i] == s) hit = i;
               end
               if (hit < 0 && model_veneer_fill < usable) begin
                  hit = model_veneer_fill;
                  model_veneer_dest[hit] = s;
                  model_veneer_fill++;
                  r.veneer_new = 1'b1;
               end
               if (hit < 0) begin
                  r.status = STAT_FULL;
               end else begin
                  r.veneer_used   = 1'b1;
                  r.veneer_index  = hit[VIDX_W-1:0];
                  r.veneer_target = s;
                  t = model_veneer_base + 32'(hit) * 32'd8 - p + addend;
               end
            end
            if (r.status == STAT_OK) r.patched_word = {w[31:24], t[25:2]};
         end
         RT_THM_CALL, RT_THM_JUMP24: begin
            up = w[15:0];
            lo = w[31:16];
            sg = up[10];
            j1 = lo[13];
            j2 = lo[11];
            t = {7'b0, sg, ~(j1 ^ sg), ~(j2 ^ sg), up[9:0], lo[10:0], 1'b0};
            if (t[24]) t = t - 32'h0200_0000;
            t = t + s - p;
            // Target must be Thumb (odd) and within the 25-bit signed reach.
            if (!t[0] || (t + 32'h00ff_ffff) > 32'h01ff_fffe) begin
               r.status = STAT_RANGE;
            end else begin
               sg = t[24];
               j1 = sg ^ ~t[23];
               j2 = sg ^ ~t[22];
               up = {up[15:11], sg, t[21:12]};
               lo = {lo[15:14], j1, lo[12], j2, t[11:1]};
               r.patched_word = {lo, up};
            end
         end
         default: r.status = STAT_UNKNOWN;
      endcase
      // Any error hands back the original word and no veneer activity.
      if (r.status != STAT_OK) begin
         r.patched_word  = w;
         r.veneer_used   = 1'b0;
         r.veneer_new    = 1'b0;
         r.veneer_index  = '0;
         r.veneer_target = '0;
      end
      return r;
   endfunction

   // Biased toward the corners of a 32-bit field.
   function automatic logic [31:0] corner_word();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h8000_0000;
         3:       return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at result %0d (%0t): %s got %h want %h",
               results_seen, $time, what, got, want);
      mismatch_count++;
   endtask

   // -----------------------------------------------------------------------
   // Response checker. Every accepted response beat is matched with the
   // oldest outstanding prediction, field by field.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_patches.size() == 0) begin
            report_mismatch("response beat with nothing outstanding", rsp_patched_word, '0);
         end else begin
            oldest_patch = predicted_patches.pop_front();
            if (rsp_patched_word !== oldest_patch.patched_word)
               report_mismatch("patched_word", rsp_patched_word, oldest_patch.patched_word);
            if (rsp_status !== oldest_patch.status)
               report_mismatch("status", 32'(rsp_status), 32'(oldest_patch.status));
            if (rsp_veneer_used !== oldest_patch.veneer_used)
               report_mismatch("veneer_used", 32'(rsp_veneer_used),
                               32'(oldest_patch.veneer_used));
            if (rsp_veneer_new !== oldest_patch.veneer_new)
               report_mismatch("veneer_new", 32'(rsp_veneer_new),
                               32'(oldest_patch.veneer_new));
            if (rsp_veneer_index !== oldest_patch.veneer_index)
               report_mismatch("veneer_index", 32'(rsp_veneer_index),
                               32'(oldest_patch.veneer_index));
            if (rsp_veneer_target !== oldest_patch.veneer_target)
               report_mismatch("veneer_target", rsp_veneer_target,
                               oldest_patch.veneer_target);
         end
         results_seen++;
      end
   end

   // The receiver decides at each falling edge whether it takes a beat at the
   // next rising edge. With a zero stall percentage it never stalls.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watchdog: a long run of cycles in which no beat moves on any channel
   // means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d predictions outstanding",
                  quiet_cycles, predicted_patches.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // One CSR write. The model copy is updated at the edge that takes the beat.
   task automatic csr_write(input logic [3:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_VENEER_BASE)
         model_veneer_base = data;
      else if (index == CSR_VENEER_ENTRIES)
         model_veneer_entries = data[4:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Presents one relocation beat, possibly after a random gap, and holds it
   // until it is taken. On the taking edge the expected response is queued:
   // the typed one for directed rows that carry it, else the model's. The
   // model runs either way so that its veneer table stays in step.
   task automatic send_relocation(input reloc_req_t rq, input logic typed,
                                  input reloc_rsp_t typed_rsp);
      reloc_rsp_t modeled;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_reloc_type   = rq.reloc_type;
      req_section_base = rq.section_base;
      req_place_offset = rq.place_offset;
      req_place_word   = rq.place_word;
      req_symbol_value = rq.symbol_value;
      req_valid        = 1'b1;
      do @(posedge clock); while (!req_ready);
      modeled = predict_relocation(rq);
      predicted_patches.push_back(typed ? typed_rsp : modeled);
   endtask

   // Lets every outstanding response drain, with valid low.
   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (predicted_patches.size() != 0) @(posedge clock);
   endtask

   // Reconfigures the block once it has gone idle. Every item returns a
   // response, so an empty prediction queue means the block has finished;
   // it is then given time to settle back into its idle state.
   task automatic reconfigure(input logic [31:0] base, input logic [31:0] entries);
      drain_responses();
      repeat (8) @(posedge clock);
      csr_write(CSR_VENEER_BASE, base);
      csr_write(CSR_VENEER_ENTRIES, entries);
   endtask

   task automatic add_row(input logic [7:0] rtype, input logic [31:0] base,
                          input logic [31:0] offset, input logic [31:0] word,
                          input logic [31:0] sym, input logic typed,
                          input logic [31:0] exp_word, input status_type exp_status);
      directed_row_t row;
      row.req.reloc_type   = rtype;
      row.req.section_base = base;
      row.req.place_offset = offset;
      row.req.place_word   = word;
      row.req.symbol_value = sym;
      row.typed            = typed;
      row.exp_word         = exp_word;
      row.exp_status       = exp_status;
      directed_rows.push_back(row);
   endtask

   // -----------------------------------------------------------------------
   // Random phase. Most beats are well-formed relocations of the supported
   // types; far ARM branches draw their targets from a small pool so that
   // veneer entries get reused as well as created. Thumb branches mostly aim
   // at a nearby odd target, and a tenth of the beats carry any type number.
   // With hold_off set, the sender stops halfway and waits for every
   // outstanding response before it carries on.
   // -----------------------------------------------------------------------
   task automatic run_random_phase(input int count, input int send_idle,
                                   input int recv_stall, input logic hold_off);
      reloc_req_t  rq;
      reloc_rsp_t  none;
      logic [31:0] p;
      logic [31:0] r;
      int          kind;
      none = '0;
      sender_idle_pct    = send_idle;
      receiver_stall_pct = recv_stall;
      for (int n = 0; n < count; n++) begin
         if (hold_off && n == count / 2) drain_responses();
         kind            = $urandom_range(99);
         rq.section_base = corner_word();
         rq.place_offset = corner_word();
         rq.place_word   = ($urandom_range(9) == 0) ? corner_word() : $urandom;
         rq.symbol_value = corner_word();
         p = rq.section_base + rq.place_offset;
         r = $urandom;
         if (kind < 30) begin
            case ($urandom_range(3))
               0:       rq.reloc_type = RT_PC24;
               1:       rq.reloc_type = RT_PLT32;
               2:       rq.reloc_type = RT_CALL;
               default: rq.reloc_type = RT_JUMP24;
            endcase
            case ($urandom_range(3))
               0:       rq.symbol_value = p + {{8{r[23]}}, r[23:0]};
               1, 2:    rq.symbol_value = far_targets[$urandom_range(23)];
               default: ;
            endcase
         end else if (kind < 45) begin
            rq.reloc_type = $urandom_range(1) ? RT_THM_CALL : RT_THM_JUMP24;
            if ($urandom_range(3) != 0)
               rq.symbol_value = p + {{9{r[22]}}, r[22:1], 1'b1};
         end else if (kind < 90) begin
            case ($urandom_range(10))
               0:       rq.reloc_type = RT_NONE;
               1:       rq.reloc_type = RT_ABS32;
               2:       rq.reloc_type = RT_TARGET1;
               3:       rq.reloc_type = RT_GLOB_DAT;
               4:       rq.reloc_type = RT_JUMP_SLOT;
               5:       rq.reloc_type = RT_RELATIVE;
               6:       rq.reloc_type = RT_REL32;
               7:       rq.reloc_type = RT_V4BX;
               8:       rq.reloc_type = RT_PREL31;
               9:       rq.reloc_type = RT_MOVW_ABS;
               default: rq.reloc_type = RT_MOVT_ABS;
            endcase
         end else begin
            rq.reloc_type = 8'($urandom);
         end
         send_relocation(rq, 1'b0, none);
      end
   endtask

   // -----------------------------------------------------------------------
   // Main sequence.
   // -----------------------------------------------------------------------
   initial begin
      reloc_rsp_t typed_rsp;
      reset            = 1'b1;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_valid        = 1'b0;
      req_reloc_type   = '0;
      req_section_base = '0;
      req_place_offset = '0;
      req_place_word   = '0;
      req_symbol_value = '0;
      model_veneer_base    = '0;
      model_veneer_entries = '0;
      model_veneer_fill    = 0;
      for (int i = 0; i < VENEER_DEPTH; i++) model_veneer_dest[i] = '0;
      for (int i = 0; i < 24; i++) far_targets[i] = $urandom;

      // Synchronous reset, released on a falling edge.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: a two-entry veneer table at address zero, which is
      // a legal veneer address.
      add_row(RT_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              1'b1, 32'hffff_ffff, STAT_OK);
      add_row(RT_NONE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, STAT_OK);
      add_row(RT_ABS32, 32'h1234_5678, 32'h10, 32'hffff_ffff, 32'h1, 1'b1, 32'h0, STAT_OK);
      add_row(RT_TARGET1, 32'h0, 32'h0, 32'h0000_1000, 32'h0000_2000, 1'b0, '0, STAT_OK);
      add_row(RT_GLOB_DAT, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 1'b1, 32'hffff_ffff, STAT_OK);
      add_row(RT_JUMP_SLOT, 32'h0, 32'h0, 32'hffff_ffff, 32'h0, 1'b1, 32'h0, STAT_OK);
      add_row(RT_RELATIVE, 32'hffff_ffff, 32'h0, 32'h1, 32'h0, 1'b1, 32'h0, STAT_OK);
      add_row(RT_REL32, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              1'b0, '0, STAT_OK);
      add_row(RT_V4BX, 32'h0, 32'h0, 32'hffff_ffff, 32'h0, 1'b1, 32'hf1a0_f00f, STAT_OK);
      add_row(RT_V4BX, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h01a0_f000, STAT_OK);
      add_row(RT_PREL31, 32'h0, 32'h4, 32'h8000_0000, 32'h10, 1'b0, '0, STAT_OK);
      add_row(RT_MOVW_ABS, 32'h0, 32'h0, 32'h000f_0fff, 32'h0, 1'b0, '0, STAT_OK);
      add_row(RT_MOVT_ABS, 32'h0, 32'h0, 32'hfff7_f7ff, 32'h1234_5678, 1'b0, '0, STAT_OK);
      // ARM branches: near, then far ones that create, reuse and create a
      // veneer, then one that finds the table full, then a near one again.
      add_row(RT_PC24, 32'h8000, 32'h0, 32'heb00_0000, 32'h8008, 1'b0, '0, STAT_OK);
      add_row(RT_PLT32, 32'h0, 32'h100, 32'heb00_0000, 32'h4000_0000, 1'b0, '0, STAT_OK);
      add_row(RT_CALL, 32'h0, 32'h200, 32'heb00_0000, 32'h4000_0000, 1'b0, '0, STAT_OK);
      add_row(RT_JUMP24, 32'h0, 32'h300, 32'hea00_0000, 32'h8000_0000, 1'b0, '0, STAT_OK);
      add_row(RT_PC24, 32'h0, 32'h100, 32'heb00_0000, 32'hc000_0000,
              1'b1, 32'heb00_0000, STAT_FULL);
      add_row(RT_PC24, 32'h0, 32'h1000, 32'h00ff_ffff, 32'h1000, 1'b0, '0, STAT_OK);
      // Thumb BL/B.W: even target, near odd target, edge of reach both ways, one past it.
      add_row(RT_THM_CALL, 32'h0, 32'h0, 32'hf800_f000, 32'h0,
              1'b1, 32'hf800_f000, STAT_RANGE);
      add_row(RT_THM_JUMP24, 32'h1000, 32'h0, 32'hf800_f000, 32'h1001, 1'b0, '0, STAT_OK);
      add_row(RT_THM_CALL, 32'h0, 32'h0, 32'hf800_f000, 32'h00ff_ffff, 1'b0, '0, STAT_OK);
      add_row(RT_THM_CALL, 32'h0, 32'h0, 32'hf800_f000, 32'hff00_0001, 1'b0, '0, STAT_OK);
      add_row(RT_THM_CALL, 32'h0, 32'h0, 32'hf800_f000, 32'h0100_0001,
              1'b1, 32'hf800_f000, STAT_RANGE);
      // Type numbers the block does not know.
      add_row(8'd255, 32'hffff_ffff, 32'h0, 32'hdead_beef, 32'h1,
              1'b1, 32'hdead_beef, STAT_UNKNOWN);
      add_row(8'd4, 32'h0, 32'h0, 32'h0bad_f00d, 32'h0, 1'b1, 32'h0bad_f00d, STAT_UNKNOWN);

      csr_write(CSR_VENEER_BASE, 32'h0);
      csr_write(CSR_VENEER_ENTRIES, 32'd2);
      foreach (directed_rows[k]) begin
         typed_rsp              = '0;
         typed_rsp.patched_word = directed_rows[k].exp_word;
         typed_rsp.status       = directed_rows[k].exp_status;
         send_relocation(directed_rows[k].req, directed_rows[k].typed, typed_rsp);
      end

      // Random phases. The fill count only grows, so the usable count is
      // raised step by step, then pushed past the table depth, then cut
      // below the fill so that the search window is narrower than the table.
      reconfigure($urandom, 32'd6);
      run_random_phase(200, 0, 0, 1'b0);
      reconfigure(32'hffff_fff8, 32'd10);
      run_random_phase(200, 62, 0, 1'b0);
      // Upper bits of the count write fall outside the register.
      reconfigure(32'h0, 32'hffff_ffec);
      run_random_phase(200, 0, 62, 1'b0);
      reconfigure($urandom, 32'd16);
      run_random_phase(250, 23, 23, 1'b1);
      reconfigure(32'hffff_ffff, 32'd31);
      run_random_phase(200, 0, 0, 1'b0);
      reconfigure($urandom, 32'd5);
      run_random_phase(150, 62, 0, 1'b0);
      reconfigure($urandom, 32'd0);
      run_random_phase(50, 23, 23, 1'b0);

      // Wait for the last responses, then a short tail for stray beats.
      drain_responses();
      receiver_stall_pct = 0;
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && predicted_patches.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/arm_rel_pkg.sv
src/arm_rel_ram.sv
src/arm_rel_patch.sv
src/arm_rel_vtab.sv
src/arm_elf_rel_relocator.sv
dv/tb_arm_elf_rel_relocator.sv
